[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent checks; all are quiet while reset is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain invariant, checked on every rising clock edge out of reset.
`define ACLS_ASSERT(lbl, clk_s, rst_n_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (prop)) \
		else $error(msg);

// Same-cycle implication.
`define ACLS_ASSERT_IMPL(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ACLS_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/acls_pkg.sv]
// ----------------------------------------------------------------------------
// acls_pkg
// Field widths, mode codes and controller/datapath bundles.
// ----------------------------------------------------------------------------
package acls_pkg;

	localparam int MODE_W  = 3;
	localparam int COORD_W = 6;
	localparam int COLS_W  = 7;
	localparam int COUNT_W = 13;

	localparam int DEF_MAX_ROWS = 64;
	localparam int DEF_MAX_COLS = 64;

	typedef logic [MODE_W-1:0]  mode_t;
	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [COLS_W-1:0]  cols_t;
	typedef logic [COUNT_W-1:0] count_t;

	localparam cols_t COLS_RESET = 7'd64;

	localparam mode_t MODE_ADD    = 3'd0;
	localparam mode_t MODE_REMOVE = 3'd1;
	localparam mode_t MODE_FIRST  = 3'd2;
	localparam mode_t MODE_NEXT   = 3'd3;
	localparam mode_t MODE_END    = 3'd4;

	// controller -> datapath
	typedef struct packed {
		logic capture;   // latch item, form cell address
		logic read;      // read flag and links at cell address
		logic eval;      // decide, update list, launch position read
		logic link;      // append: old tail's next link -> new cell
		logic load;      // load result register
		logic clear;     // post-reset sweep of the active flags
	} acls_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_link;
		logic clear_last;
	} acls_status_t;

endpackage

[rtl/acls_if.sv]
// ----------------------------------------------------------------------------
// acls channel interfaces
// Valid/ready request and response channels of the active cell set.
// ----------------------------------------------------------------------------
interface acls_req_if;
	import acls_pkg::*;

	logic   valid;
	logic   ready;
	mode_t  mode;
	coord_t cell_row;
	coord_t cell_col;

	modport source (output valid, mode, cell_row, cell_col, input ready);
	modport sink   (input valid, mode, cell_row, cell_col, output ready);
endinterface

interface acls_rsp_if;
	import acls_pkg::*;

	logic   valid;
	logic   ready;
	logic   found;
	coord_t out_row;
	coord_t out_col;
	logic   changed;
	count_t active_count;

	modport source (output valid, found, out_row, out_col, changed, active_count,
		input ready);
	modport sink   (input valid, found, out_row, out_col, changed, active_count,
		output ready);
endinterface

[rtl/acls_ctrl.sv]
// ----------------------------------------------------------------------------
// acls_ctrl
// Sequencer for the active cell set: clear sweep, read, evaluate, respond.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module acls_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  acls_pkg::acls_status_t status,
	output acls_pkg::acls_cmd_t    cmd
);
	import acls_pkg::*;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_READ  = 6'b000100,
		ST_EVAL  = 6'b001000,
		ST_LINK  = 6'b010000,
		ST_RESP  = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (status.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_READ;
				end
			end
			ST_READ: begin
				cmd.read = 1'b1;
				state_d  = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = status.need_link ? ST_LINK : ST_RESP;
			end
			ST_LINK: begin
				cmd.link = 1'b1;
				state_d  = ST_RESP;
			end
			ST_RESP: begin
				if (out_free) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`ACLS_ASSERT_IMPL(a_link_after_eval, clk, arst_n, state_q == ST_LINK, $past(state_q) == ST_EVAL, "link step without evaluate")
	`ACLS_ASSERT_NEXT(a_load_shows, clk, arst_n, cmd.load, out_valid_q, "loaded result not presented")
	`ACLS_ASSERT_NEXT(a_accept_reads, clk, arst_n, in_valid && in_ready, state_q == ST_READ, "accepted item not read")

endmodule

[rtl/acls_dp.sv]
// ----------------------------------------------------------------------------
// acls_dp
// Datapath: width register, cell address, flag/link/position memories,
// head/tail/marker/count registers and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module acls_dp #(
	parameter int MAX_ROWS = acls_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = acls_pkg::DEF_MAX_COLS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  acls_pkg::cols_t        cfg_wdata,
	input  acls_pkg::acls_cmd_t    cmd,
	output acls_pkg::acls_status_t status,
	input  acls_pkg::mode_t        mode,
	input  acls_pkg::coord_t       cell_row,
	input  acls_pkg::coord_t       cell_col,
	output logic                   found,
	output acls_pkg::coord_t       out_row,
	output acls_pkg::coord_t       out_col,
	output logic                   changed,
	output acls_pkg::count_t       active_count
);
	import acls_pkg::*;

	localparam int CELLS   = MAX_ROWS * MAX_COLS;
	localparam int LW      = $clog2(CELLS + 1);
	localparam int IW      = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int ROW_CAP = (MAX_ROWS > (1 << COORD_W)) ? (1 << COORD_W) : MAX_ROWS;
	localparam int COL_CAP = (MAX_COLS > ((1 << COLS_W) - 1)) ? ((1 << COLS_W) - 1) : MAX_COLS;
	localparam int PW      = COORD_W + COLS_W + 1;
	localparam int POS_W   = 2 * COORD_W;
	localparam logic [LW-1:0] NIL = LW'(CELLS);

	// configuration
	cols_t cols_q;
	cols_t eff_cols;

	// captured item
	mode_t   mode_q;
	coord_t  row_q;
	coord_t  col_q;
	logic    [IW-1:0] addr_q;
	logic    inr_q;

	// list state
	logic [LW-1:0] head_q, tail_q, marker_q, count_q;
	logic [LW-1:0] ltail_q, hit_q;
	logic [IW-1:0] clr_q;
	logic          changed_q;

	// memories and their read registers
	logic             flag_mem [CELLS];
	logic [LW-1:0]    next_mem [CELLS];
	logic [LW-1:0]    prev_mem [CELLS];
	logic [POS_W-1:0] pos_mem  [CELLS];
	logic             flag_rd_q;
	logic [LW-1:0]    next_rd_q, prev_rd_q;
	logic [POS_W-1:0] pos_rd_q;

	// result register
	logic   found_q, changed_out_q;
	coord_t out_row_q, out_col_q;
	count_t count_out_q;

	// address forming
	logic [PW-1:0]    sum_d;
	logic [PW+IW-1:0] sum_wide;
	logic [IW-1:0]    addr_d;
	logic             inr_d;

	// evaluate decode
	logic          is_add, is_rem, do_add, do_rem, head_nil;
	logic          p_ok, n_ok;
	logic [LW-1:0] next_hit, hit_d;

	// memory ports
	logic          flag_we, flag_wd;
	logic [IW-1:0] flag_wa;
	logic          next_we;
	logic [IW-1:0] next_wa;
	logic [LW-1:0] next_wd;
	logic          prev_we;
	logic [IW-1:0] prev_wa;
	logic [LW-1:0] prev_wd;
	logic          pos_re;
	logic [IW-1:0] pos_a;

	always_comb begin
		eff_cols = (cols_q > COL_CAP[COLS_W-1:0]) ? COL_CAP[COLS_W-1:0] : cols_q;
		inr_d    = ({1'b0, cell_row} < ROW_CAP[COORD_W:0]) && ({1'b0, cell_col} < eff_cols);
		sum_d    = PW'(cell_row) * PW'(eff_cols) + PW'(cell_col);
		sum_wide = {{IW{1'b0}}, sum_d};
		addr_d   = sum_wide[IW-1:0];
	end

	always_comb begin
		head_nil = (head_q == NIL);
		is_add   = (mode_q == MODE_ADD) && inr_q;
		is_rem   = (mode_q == MODE_REMOVE) && inr_q;
		do_add   = cmd.eval && is_add && !flag_rd_q;
		do_rem   = cmd.eval && is_rem && flag_rd_q;
		p_ok     = (prev_rd_q < NIL);
		n_ok     = (next_rd_q < NIL);

		// walk stops in front of the marker; inactive cells have no successor
		next_hit = (inr_q && flag_rd_q) ? next_rd_q : NIL;
		if (next_hit == marker_q) begin
			next_hit = NIL;
		end
		case (mode_q)
			MODE_FIRST: hit_d = head_q;
			MODE_NEXT:  hit_d = next_hit;
			default:    hit_d = NIL;
		endcase

		status.need_link  = is_add && !flag_rd_q && !head_nil && (tail_q < NIL);
		status.clear_last = (clr_q == IW'(CELLS - 1));
	end

	// port muxing: each memory sees at most one access a cycle
	always_comb begin
		flag_we = cmd.clear || do_add || do_rem;
		flag_wa = cmd.clear ? clr_q : addr_q;
		flag_wd = do_add;

		next_we = do_add || (do_rem && p_ok) || cmd.link;
		if (cmd.link) begin
			next_wa = ltail_q[IW-1:0];
			next_wd = LW'(addr_q);
		end else if (do_add) begin
			next_wa = addr_q;
			next_wd = NIL;
		end else begin
			next_wa = prev_rd_q[IW-1:0];
			next_wd = next_rd_q;
		end

		prev_we = do_add || (do_rem && n_ok);
		if (do_add) begin
			prev_wa = addr_q;
			prev_wd = head_nil ? NIL : tail_q;
		end else begin
			prev_wa = next_rd_q[IW-1:0];
			prev_wd = prev_rd_q;
		end

		pos_re = cmd.eval && (hit_d < NIL);
		pos_a  = do_add ? addr_q : hit_d[IW-1:0];
	end

	always_ff @(posedge clk) begin
		if (flag_we) begin
			flag_mem[flag_wa] <= flag_wd;
		end
		if (cmd.read) begin
			flag_rd_q <= flag_mem[addr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (next_we) begin
			next_mem[next_wa] <= next_wd;
		end
		if (cmd.read) begin
			next_rd_q <= next_mem[addr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (prev_we) begin
			prev_mem[prev_wa] <= prev_wd;
		end
		if (cmd.read) begin
			prev_rd_q <= prev_mem[addr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (do_add) begin
			pos_mem[pos_a] <= {row_q, col_q};
		end
		if (pos_re) begin
			pos_rd_q <= pos_mem[pos_a];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode;
			row_q  <= cell_row;
			col_q  <= cell_col;
			addr_q <= addr_d;
			inr_q  <= inr_d;
		end
		if (cmd.eval) begin
			ltail_q   <= tail_q;
			hit_q     <= hit_d;
			changed_q <= do_add || do_rem;
		end
		if (cmd.load) begin
			found_q       <= (hit_q < NIL);
			out_row_q     <= (hit_q < NIL) ? pos_rd_q[POS_W-1:COORD_W] : '0;
			out_col_q     <= (hit_q < NIL) ? pos_rd_q[COORD_W-1:0] : '0;
			changed_out_q <= changed_q;
			count_out_q   <= COUNT_W'(count_q);
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q   <= COLS_RESET;
			head_q   <= NIL;
			tail_q   <= NIL;
			marker_q <= NIL;
			count_q  <= '0;
			clr_q    <= '0;
		end else begin
			if (cfg_we) begin
				cols_q <= cfg_wdata;
			end
			if (cmd.clear) begin
				clr_q <= clr_q + 1'b1;
			end
			if (do_add) begin
				if (head_nil) begin
					head_q <= LW'(addr_q);
				end
				tail_q <= LW'(addr_q);
				if (marker_q == NIL) begin
					marker_q <= LW'(addr_q);
				end
				count_q <= count_q + 1'b1;
			end
			if (do_rem) begin
				if (!p_ok) begin
					head_q <= next_rd_q;
				end
				if (!n_ok) begin
					tail_q <= prev_rd_q;
				end
				count_q <= count_q - 1'b1;
			end
			if (cmd.eval && (mode_q == MODE_END)) begin
				marker_q <= NIL;
			end
		end
	end

	assign found        = found_q;
	assign out_row      = out_row_q;
	assign out_col      = out_col_q;
	assign changed      = changed_out_q;
	assign active_count = count_out_q;

	`ACLS_ASSERT(a_head_vs_count, clk, arst_n, (head_q == NIL) == (count_q == {LW{1'b0}}), "head and count disagree on empty set")
	`ACLS_ASSERT(a_head_vs_tail, clk, arst_n, (head_q == NIL) == (tail_q == NIL), "head and tail disagree on empty set")
	`ACLS_ASSERT_NEXT(a_add_counts, clk, arst_n, do_add, count_q == $past(count_q) + 1'b1, "add did not bump count")

endmodule

[rtl/active_cell_linked_set_core.sv]
// ----------------------------------------------------------------------------
// active_cell_linked_set_core
// Set of active grid cells kept as a doubly linked list in per-cell memories.
// ----------------------------------------------------------------------------
// The block holds the active cells of a MAX_ROWS x MAX_COLS grid as a
// doubly linked list, one memory slot per cell, addressed by
// row * columns_in_use + col (width clamped to MAX_COLS). Items on req add a
// cell at the tail, remove a cell, return the head, return the cell after a
// given one (the walk ends in front of the first cell added since the last
// end-of-iteration item), or end the iteration. Every item gives exactly one
// result on rsp. Out-of-range cells are ignored. One item at a time is in
// work: accept, read, evaluate and result, plus a link step for an add onto
// a non-empty list, because the old tail's next link and the new cell's next
// link share the single port of the next-link memory. After reset a sweep
// clears the active flags of all MAX_ROWS * MAX_COLS cells, during which
// req.ready stays low; cfg writes are taken at any time.
// The rsp side has its own result register, so a new item can be accepted
// while the previous result waits.
// ----------------------------------------------------------------------------
module active_cell_linked_set_core #(
	parameter int MAX_ROWS = acls_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = acls_pkg::DEF_MAX_COLS
) (
	input  logic            clk,
	input  logic            arst_n,
	// width register, written whenever cfg_we is high
	input  logic            cfg_we,
	input  acls_pkg::cols_t cfg_wdata,
	acls_req_if.sink        req,
	acls_rsp_if.source      rsp
);
	import acls_pkg::*;

	acls_cmd_t    cmd;
	acls_status_t status;

	// sequencer: clear sweep, then accept / read / evaluate / (link) / respond
	acls_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// memories, list pointers and the result register
	acls_dp #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.cmd          (cmd),
		.status       (status),
		.mode         (req.mode),
		.cell_row     (req.cell_row),
		.cell_col     (req.cell_col),
		.found        (rsp.found),
		.out_row      (rsp.out_row),
		.out_col      (rsp.out_col),
		.changed      (rsp.changed),
		.active_count (rsp.active_count)
	);

endmodule
